// ===== src/lfp_pkg.sv =====
// lfp_pkg: shared constants, frame geometry and the command record
// passed from the classifying front end to the byte sequencer. no dependencies.
`default_nettype none

package lfp_pkg;

  // frame geometry
  localparam int STRIP_COUNT         = 8;
  localparam int LEDS_IN_STRIP       = 64;
  localparam int ENTRIES_PER_CHANNEL = 257;

  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] VIDEO_ITEMS = POS_W'(STRIP_COUNT * LEDS_IN_STRIP);
  localparam logic [POS_W-1:0] TABLE_ITEMS = POS_W'(3 * ENTRIES_PER_CHANNEL);

  // packet layout
  localparam logic [7:0] PKT_BYTES       = 8'd64;
  localparam logic [4:0] LEDS_PER_PKT    = 5'd21;
  localparam logic [4:0] ENTRIES_PER_PKT = 5'd31;

  // control byte flag positions
  localparam int CTRL_KIND_BIT  = 6;
  localparam int CTRL_FINAL_BIT = 5;

  // command queue
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // one item's worth of work for the byte sequencer
  typedef struct packed {
    logic [7:0]  ctrl;       // control byte, used when hdr_len != 0
    logic [1:0]  hdr_len;    // 0, 1 (video) or 2 (lookup) header bytes
    logic [23:0] data;       // payload bytes, first byte in [7:0], unused bytes zero
    logic [5:0]  last_idx;   // index of the last byte this item emits
    logic        pkt_end;    // last byte closes a packet
    logic        frame_end;  // last byte closes the frame
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/lfp_front.sv =====
// lfp_front: tracks frame, packet and slot position for every accepted item
// and builds one sequencer command for it. depends on lfp_pkg.
`default_nettype none

module lfp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          op,
  input  wire logic [7:0]    red,
  input  wire logic [7:0]    green,
  input  wire logic [7:0]    blue,
  input  wire logic [15:0]   table_entry,
  output lfp_pkg::cmd_t      cmd
);
  import lfp_pkg::*;

  logic             frame_active_r, frame_active_nxt;
  logic             frame_is_table_r, frame_is_table_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [4:0]       pkt_r, pkt_nxt;
  logic [4:0]       slot_r, slot_nxt;

  logic             tbl;
  logic [POS_W-1:0] pos, pos_n, total, remaining;
  logic [4:0]       pkt, slot, slot_n, per;
  logic             final_flag, final_item;
  logic [1:0]       hdr_len, data_len;
  logic [7:0]       fill, pad, run_len;

  // effective state: a new frame starts from zero with the kind taken from op
  always_comb begin
    tbl  = frame_active_r ? frame_is_table_r : op;
    pos  = frame_active_r ? pos_r  : '0;
    pkt  = frame_active_r ? pkt_r  : '0;
    slot = frame_active_r ? slot_r : '0;
  end

  // classify the item
  always_comb begin
    total      = tbl ? TABLE_ITEMS : VIDEO_ITEMS;
    per        = tbl ? ENTRIES_PER_PKT : LEDS_PER_PKT;
    remaining  = total - pos;
    final_flag = remaining <= {{(POS_W-5){1'b0}}, per};
    hdr_len    = (slot == 5'd0) ? (tbl ? 2'd2 : 2'd1) : 2'd0;
    data_len   = tbl ? 2'd2 : 2'd3;
    slot_n     = slot + 5'd1;
    pos_n      = pos + POS_W'(1);
    final_item = pos_n >= total;
    // packet bytes filled after this item
    fill       = tbl ? (8'd2 + {2'b0, slot_n, 1'b0})
                     : (8'd1 + {2'b0, slot_n, 1'b0} + {3'b0, slot_n});
    pad        = final_item ? (PKT_BYTES - fill) : 8'd0;
    run_len    = {6'b0, hdr_len} + {6'b0, data_len} + pad;

    cmd.ctrl = 8'd0;
    cmd.ctrl[4:0]           = pkt;
    cmd.ctrl[CTRL_KIND_BIT]  = tbl;
    cmd.ctrl[CTRL_FINAL_BIT] = final_flag;
    cmd.hdr_len   = hdr_len;
    cmd.data      = tbl ? {8'd0, table_entry[15:8], table_entry[7:0]}
                        : {blue, green, red};
    cmd.last_idx  = 6'(run_len - 8'd1);
    cmd.pkt_end   = final_item | (fill >= PKT_BYTES);
    cmd.frame_end = final_item;
  end

  // next position
  always_comb begin
    frame_active_nxt   = frame_active_r;
    frame_is_table_nxt = frame_is_table_r;
    pos_nxt            = pos_r;
    pkt_nxt            = pkt_r;
    slot_nxt           = slot_r;
    if (accept) begin
      if (final_item) begin
        frame_active_nxt   = 1'b0;
        frame_is_table_nxt = 1'b0;
        pos_nxt            = '0;
        pkt_nxt            = '0;
        slot_nxt           = '0;
      end else begin
        frame_active_nxt   = 1'b1;
        frame_is_table_nxt = tbl;
        pos_nxt            = pos_n;
        if (slot_n >= per) begin
          slot_nxt = '0;
          pkt_nxt  = pkt + 5'd1;
        end else begin
          slot_nxt = slot_n;
          pkt_nxt  = pkt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r   <= 1'b0;
      frame_is_table_r <= 1'b0;
      pos_r            <= '0;
      pkt_r            <= '0;
      slot_r           <= '0;
    end else begin
      frame_active_r   <= frame_active_nxt;
      frame_is_table_r <= frame_is_table_nxt;
      pos_r            <= pos_nxt;
      pkt_r            <= pkt_nxt;
      slot_r           <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lfp_cmd_fifo.sv =====
// lfp_cmd_fifo: short command queue between front end and byte sequencer.
// depends on lfp_pkg.
`default_nettype none

module lfp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire lfp_pkg::cmd_t wr_cmd,
  output logic               full,
  output logic               rd_valid,
  output lfp_pkg::cmd_t      rd_cmd,
  input  wire logic          rd_en
);
  import lfp_pkg::*;

  cmd_t              mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full     = count_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & rd_valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + CMDQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + CMDQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + {{CMDQ_AW{1'b0}}, do_wr} - {{CMDQ_AW{1'b0}}, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/lfp_back.sv =====
// lfp_back: byte sequencer, walks one command byte by byte into a
// registered output beat. depends on lfp_pkg.
`default_nettype none

module lfp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire lfp_pkg::cmd_t cmd,
  output logic               cmd_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         data_byte,
  output logic               last_of_run,
  output logic               packet_end,
  output logic               frame_end
);
  import lfp_pkg::*;

  logic [5:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r, pend_r, fend_r;

  logic       load, is_last;
  logic [5:0] j;
  logic [7:0] cur_byte;

  assign load    = cmd_valid & (~out_valid_r | pop);
  assign is_last = idx_r == cmd.last_idx;
  assign cmd_pop = load & is_last;

  // pick the byte at the current index: header, payload, then zero padding
  always_comb begin
    j        = idx_r - {4'b0, cmd.hdr_len};
    cur_byte = 8'd0;
    if (idx_r < {4'b0, cmd.hdr_len}) begin
      cur_byte = (idx_r == 6'd0) ? cmd.ctrl : 8'd0;
    end else begin
      case (j)
        6'd0:    cur_byte = cmd.data[7:0];
        6'd1:    cur_byte = cmd.data[15:8];
        6'd2:    cur_byte = cmd.data[23:16];
        default: cur_byte = 8'd0;
      endcase
    end
  end

  // index and output valid
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 6'd0 : idx_r + 6'd1;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      pend_r <= is_last & cmd.pkt_end;
      fend_r <= is_last & cmd.frame_end;
    end
  end

  assign empty       = ~out_valid_r;
  assign data_byte   = byte_r;
  assign last_of_run = last_r;
  assign packet_end  = pend_r;
  assign frame_end   = fend_r;

endmodule

`default_nettype wire

// ===== src/led_frame_usb_packetizer.sv =====
// led_frame_usb_packetizer: top level, front end, command queue and byte sequencer.
// depends on lfp_pkg, lfp_front, lfp_cmd_fifo, lfp_back.
`default_nettype none

// Frames LED color items (video frame, 512 items) or 16-bit lookup entries
// (lookup frame, 771 items) into 64-byte packets; the op of a frame's first
// item picks the kind. An item is taken whenever the four-entry command
// queue has room, so items can arrive back to back until it fills. Bytes
// leave at one per cycle from the output register while pop is held, so the
// sustained rate is set by the byte sequencer: 3 bytes per LED item plus 1 for
// each packet's control byte, 2 per lookup entry plus 2 per packet header, and
// 39 more for zero padding on the last item of a video frame, 8 more on the
// last item of a lookup frame.

module led_frame_usb_packetizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [15:0] in_table_entry,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_data_byte,
  output logic             out_last_of_run,
  output logic             out_packet_end,
  output logic             out_frame_end
);
  import lfp_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic accept, head_valid, head_pop;

  assign accept = push & ~full;

  // position tracking and classification
  lfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_op),
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .table_entry (in_table_entry),
    .cmd         (front_cmd)
  );

  // decoupling queue
  lfp_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_valid (head_valid),
    .rd_cmd   (head_cmd),
    .rd_en    (head_pop)
  );

  // byte emission
  lfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .cmd_pop     (head_pop),
    .pop         (pop),
    .empty       (empty),
    .data_byte   (out_data_byte),
    .last_of_run (out_last_of_run),
    .packet_end  (out_packet_end),
    .frame_end   (out_frame_end)
  );

endmodule

`default_nettype wire

// ===== src/lfp_checker.sv =====
// lfp_checker: port-level checks on the packet byte stream, bound to the top level.
// depends on led_frame_usb_packetizer ports only.
`default_nettype none

module lfp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_last_of_run,
  input wire logic       out_packet_end,
  input wire logic       out_frame_end
);

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data_byte)))
    else $error("waiting beat changed before pop");

  // a packet closes only on an item's last byte
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_packet_end) |-> out_last_of_run)
    else $error("packet end off the last byte of a run");

  // a frame closes only where a packet closes
  a_fend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_packet_end)
    else $error("frame end without packet end");

  // the byte after a frame end is a first packet's control byte
  a_new_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_frame_end) |=>
      (empty || (out_data_byte[4:0] == 5'd0 && !out_data_byte[7])))
    else $error("new frame does not start at packet zero");

endmodule

bind led_frame_usb_packetizer lfp_checker u_lfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_data_byte   (out_data_byte),
  .out_last_of_run (out_last_of_run),
  .out_packet_end  (out_packet_end),
  .out_frame_end   (out_frame_end)
);

`default_nettype wire
